// ===== design/rss_pkg.sv =====
// ----------------------------------------------------------------------------
// rss_pkg: shared types and constants of the record sort and search block
// Record layout, controller command and status groups, state and select codes,
// and the name normalizing function.
// ----------------------------------------------------------------------------
package rss_pkg;

    localparam int MaxRecords = 16;
    localparam int IDX_W      = $clog2(MaxRecords);
    localparam int CNT_W      = $clog2(MaxRecords + 1);

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_ANSWER = 1'b1;

    typedef struct packed {
        logic [63:0] head;
        logic [7:0]  tail;
    } name_t;

    typedef struct packed {
        name_t       name;
        logic [15:0] apartment;
        logic [9:0]  area_code;
        logic [23:0] phone_number;
    } rec_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT_START,
        ST_SORT_RDI,
        ST_SORT_LDI,
        ST_SORT_CMP,
        ST_SORT_WRI,
        ST_EMIT_START,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_SEARCH_START,
        ST_SEARCH_RD,
        ST_SEARCH_CMP,
        ST_SEARCH_MISS
    } state_t;

    typedef enum logic [1:0] {
        RD_I,
        RD_J,
        RD_JP1
    } rd_sel_t;

    typedef enum logic {
        WR_I,
        WR_J
    } wr_sel_t;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_RECORD,
        OUT_HIT,
        OUT_MISS
    } out_sel_t;

    typedef struct packed {
        logic     accept;
        logic     i_clear;
        logic     i_inc;
        logic     j_zero;
        logic     j_ip1;
        logic     j_inc;
        rd_sel_t  rd_sel;
        logic     wr_en;
        wr_sel_t  wr_sel;
        logic     cur_load;
        out_sel_t out_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic count_lt2;
        logic count_zero;
        logic i_last;
        logic j_last;
        logic greater;
        logic match;
        logic out_free;
    } dp_status_t;

    // A name ends at its first zero byte; every byte after it is cleared.
    function automatic name_t normalize(logic [63:0] head, logic [7:0] tail);
        name_t      n;
        logic       keep;
        logic [7:0] b;
        keep = 1'b1;
        n    = '0;
        for (int k = 0; k < 8; k++) begin
            b    = head[63 - 8 * k -: 8];
            keep = keep & (b != 8'd0);
            n.head[63 - 8 * k -: 8] = keep ? b : 8'd0;
        end
        n.tail = keep ? tail : 8'd0;
        return n;
    endfunction

endpackage

// ===== design/rss_ctrl.sv =====
// ----------------------------------------------------------------------------
// rss_ctrl: sequencer of the record sort and search block
// Steps the datapath through loads, the exchange sort, the sorted emission and
// the linear search.
// ----------------------------------------------------------------------------
module rss_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                mode,
    input  logic                last,
    input  rss_pkg::dp_status_t status,
    output rss_pkg::dp_cmd_t    cmd
);

    rss_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rss_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.rd_sel   = rss_pkg::RD_J;
        cmd.wr_sel   = rss_pkg::WR_J;
        cmd.out_sel  = rss_pkg::OUT_NONE;
        unique case (state_reg)
            rss_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    if (mode == rss_pkg::MODE_SEARCH)
                    begin
                        state_next = rss_pkg::ST_SEARCH_START;
                    end
                    else if (last)
                    begin
                        state_next = rss_pkg::ST_SORT_START;
                    end
                end
            end
            rss_pkg::ST_SORT_START:
            begin
                cmd.i_clear = 1'b1;
                state_next  = status.count_lt2 ? rss_pkg::ST_EMIT_START
                                               : rss_pkg::ST_SORT_RDI;
            end
            rss_pkg::ST_SORT_RDI:
            begin
                cmd.rd_sel = rss_pkg::RD_I;
                cmd.j_ip1  = 1'b1;
                state_next = rss_pkg::ST_SORT_LDI;
            end
            rss_pkg::ST_SORT_LDI:
            begin
                cmd.cur_load = 1'b1;
                cmd.rd_sel   = rss_pkg::RD_J;
                state_next   = rss_pkg::ST_SORT_CMP;
            end
            rss_pkg::ST_SORT_CMP:
            begin
                // A greater held record moves to slot j and the smaller one is held.
                cmd.wr_en    = status.greater;
                cmd.wr_sel   = rss_pkg::WR_J;
                cmd.cur_load = status.greater;
                if (status.j_last)
                begin
                    state_next = rss_pkg::ST_SORT_WRI;
                end
                else
                begin
                    cmd.j_inc  = 1'b1;
                    cmd.rd_sel = rss_pkg::RD_JP1;
                end
            end
            rss_pkg::ST_SORT_WRI:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = rss_pkg::WR_I;
                if (status.i_last)
                begin
                    state_next = rss_pkg::ST_EMIT_START;
                end
                else
                begin
                    cmd.i_inc  = 1'b1;
                    state_next = rss_pkg::ST_SORT_RDI;
                end
            end
            rss_pkg::ST_EMIT_START:
            begin
                cmd.j_zero = 1'b1;
                state_next = rss_pkg::ST_EMIT_RD;
            end
            rss_pkg::ST_EMIT_RD:
            begin
                cmd.rd_sel = rss_pkg::RD_J;
                state_next = rss_pkg::ST_EMIT_OUT;
            end
            rss_pkg::ST_EMIT_OUT:
            begin
                cmd.rd_sel = rss_pkg::RD_J;
                if (status.out_free)
                begin
                    cmd.out_sel = rss_pkg::OUT_RECORD;
                    if (status.j_last)
                    begin
                        state_next = rss_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.j_inc  = 1'b1;
                        cmd.rd_sel = rss_pkg::RD_JP1;
                    end
                end
            end
            rss_pkg::ST_SEARCH_START:
            begin
                cmd.j_zero = 1'b1;
                state_next = status.count_zero ? rss_pkg::ST_SEARCH_MISS
                                               : rss_pkg::ST_SEARCH_RD;
            end
            rss_pkg::ST_SEARCH_RD:
            begin
                cmd.rd_sel = rss_pkg::RD_J;
                state_next = rss_pkg::ST_SEARCH_CMP;
            end
            rss_pkg::ST_SEARCH_CMP:
            begin
                if (status.match)
                begin
                    cmd.rd_sel = rss_pkg::RD_J;
                    if (status.out_free)
                    begin
                        cmd.out_sel = rss_pkg::OUT_HIT;
                        state_next  = rss_pkg::ST_IDLE;
                    end
                end
                else if (status.j_last)
                begin
                    state_next = rss_pkg::ST_SEARCH_MISS;
                end
                else
                begin
                    cmd.j_inc  = 1'b1;
                    cmd.rd_sel = rss_pkg::RD_JP1;
                end
            end
            rss_pkg::ST_SEARCH_MISS:
            begin
                if (status.out_free)
                begin
                    cmd.out_sel = rss_pkg::OUT_MISS;
                    state_next  = rss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rss_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/rss_datapath.sv =====
// ----------------------------------------------------------------------------
// rss_datapath: record store, sort and search datapath
// Holds the record memory, the table count, the sort indexes, the held record
// of the current sort pass, the search key and the result register.
// ----------------------------------------------------------------------------
module rss_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  rss_pkg::dp_cmd_t    cmd,
    output rss_pkg::dp_status_t status,
    input  logic                mode,
    input  logic [63:0]         name_head,
    input  logic [7:0]          name_tail,
    input  logic [15:0]         apartment,
    input  logic [9:0]          area_code,
    input  logic [23:0]         phone_number,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                kind,
    output logic [63:0]         out_name_head,
    output logic [7:0]          out_name_tail,
    output logic [15:0]         out_apartment,
    output logic [9:0]          out_area_code,
    output logic [23:0]         out_phone_number,
    output logic [3:0]          position,
    output logic                found,
    output logic                end_of_run
);

    localparam int IdxW = rss_pkg::IDX_W;
    localparam int CntW = rss_pkg::CNT_W;

    rss_pkg::rec_t mem [rss_pkg::MaxRecords];
    rss_pkg::rec_t rdata_reg;
    rss_pkg::rec_t cur_reg;
    rss_pkg::name_t key_reg;
    rss_pkg::name_t in_name;

    logic [CntW-1:0] count_reg, count_next;
    logic            closed_reg, closed_next;
    logic [IdxW-1:0] i_reg, i_next;
    logic [IdxW-1:0] j_reg, j_next;
    logic            full;
    logic            load_we;

    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    rss_pkg::rec_t   wr_data;
    logic [IdxW-1:0] rd_addr;

    logic            out_valid_reg, out_valid_next;
    logic            kind_reg;
    logic [63:0]     head_reg;
    logic [7:0]      tail_reg;
    logic [15:0]     apt_reg;
    logic [9:0]      area_reg;
    logic [23:0]     phone_reg;
    logic [3:0]      pos_reg;
    logic            found_reg;
    logic            eor_reg;

    assign in_name = rss_pkg::normalize(name_head, name_tail);

    // A closed table is dropped by the next load, so it is never full then.
    assign full    = !closed_reg && (count_reg == CntW'(rss_pkg::MaxRecords));
    assign load_we = cmd.accept && (mode == rss_pkg::MODE_LOAD) && !full;

    always_comb
    begin
        count_next  = count_reg;
        closed_next = closed_reg;
        if (cmd.accept && (mode == rss_pkg::MODE_LOAD))
        begin
            closed_next = last;
            if (closed_reg)
            begin
                count_next = CntW'(1);
            end
            else if (!full)
            begin
                count_next = count_reg + CntW'(1);
            end
        end
    end

    always_comb
    begin
        i_next = i_reg;
        if (cmd.i_clear)
        begin
            i_next = '0;
        end
        else if (cmd.i_inc)
        begin
            i_next = i_reg + IdxW'(1);
        end
    end

    always_comb
    begin
        j_next = j_reg;
        if (cmd.j_zero)
        begin
            j_next = '0;
        end
        else if (cmd.j_ip1)
        begin
            j_next = i_reg + IdxW'(1);
        end
        else if (cmd.j_inc)
        begin
            j_next = j_reg + IdxW'(1);
        end
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            rss_pkg::RD_I:   rd_addr = i_reg;
            rss_pkg::RD_J:   rd_addr = j_reg;
            rss_pkg::RD_JP1: rd_addr = j_reg + IdxW'(1);
            default:         rd_addr = j_reg;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = j_reg;
        wr_data = cur_reg;
        if (load_we)
        begin
            wr_en                = 1'b1;
            wr_addr              = closed_reg ? '0 : count_reg[IdxW-1:0];
            wr_data.name         = in_name;
            wr_data.apartment    = apartment;
            wr_data.area_code    = area_code;
            wr_data.phone_number = phone_number;
        end
        else if (cmd.wr_en)
        begin
            wr_en   = 1'b1;
            wr_addr = (cmd.wr_sel == rss_pkg::WR_I) ? i_reg : j_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cur_load)
        begin
            cur_reg <= rdata_reg;
        end
        if (cmd.accept)
        begin
            key_reg <= in_name;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            closed_reg    <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            closed_reg    <= closed_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.out_sel != rss_pkg::OUT_NONE)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.out_sel)
            rss_pkg::OUT_RECORD:
            begin
                kind_reg  <= rss_pkg::KIND_RECORD;
                head_reg  <= rdata_reg.name.head;
                tail_reg  <= rdata_reg.name.tail;
                apt_reg   <= rdata_reg.apartment;
                area_reg  <= rdata_reg.area_code;
                phone_reg <= rdata_reg.phone_number;
                pos_reg   <= 4'(j_reg);
                found_reg <= 1'b0;
                eor_reg   <= status.j_last;
            end
            rss_pkg::OUT_HIT:
            begin
                kind_reg  <= rss_pkg::KIND_ANSWER;
                head_reg  <= '0;
                tail_reg  <= '0;
                apt_reg   <= '0;
                area_reg  <= rdata_reg.area_code;
                phone_reg <= rdata_reg.phone_number;
                pos_reg   <= 4'(j_reg);
                found_reg <= 1'b1;
                eor_reg   <= 1'b1;
            end
            rss_pkg::OUT_MISS:
            begin
                kind_reg  <= rss_pkg::KIND_ANSWER;
                head_reg  <= '0;
                tail_reg  <= '0;
                apt_reg   <= '0;
                area_reg  <= '0;
                phone_reg <= '0;
                pos_reg   <= '0;
                found_reg <= 1'b0;
                eor_reg   <= 1'b1;
            end
            default:
            begin
                kind_reg <= kind_reg;
            end
        endcase
    end

    assign status.count_lt2  = count_reg < CntW'(2);
    assign status.count_zero = count_reg == '0;
    assign status.i_last     = (CntW'(i_reg) + CntW'(2)) == count_reg;
    assign status.j_last     = (CntW'(j_reg) + CntW'(1)) == count_reg;
    assign status.greater    = cur_reg.name > rdata_reg.name;
    assign status.match      = rdata_reg.name == key_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign kind             = kind_reg;
    assign out_name_head    = head_reg;
    assign out_name_tail    = tail_reg;
    assign out_apartment    = apt_reg;
    assign out_area_code    = area_reg;
    assign out_phone_number = phone_reg;
    assign position         = pos_reg;
    assign found            = found_reg;
    assign end_of_run       = eor_reg;

endmodule

// ===== design/record_sort_and_search.sv =====
// ----------------------------------------------------------------------------
// record_sort_and_search: phone-book table with exchange sort and search
// Loads records into a table, sorts it by name when a batch closes and emits
// it in order, and answers name searches with the first matching record.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Beat contents
//  -------  -------------------  ---------------------------------------------
//  input    in_valid / in_ready  mode, name_head, name_tail, apartment,
//                                area_code, phone_number, last
//  output   out_valid/out_ready  kind, out_name_head, out_name_tail,
//                                out_apartment, out_area_code,
//                                out_phone_number, position, found, end_of_run
//
// A load without last leaves the sequencer idle and ready for the next beat. A
// closing load sorts the table with one compare per cycle on the single-read
// record memory, then, after the emit start and read states, emits one record
// per cycle while the output is not stalled.
// Reset clears the table count, the batch flag and the sequencer; the record
// memory is not cleared. A stalled output holds the sequencer in place.
// ----------------------------------------------------------------------------
module record_sort_and_search (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [63:0] name_head,
    input  logic [7:0]  name_tail,
    input  logic [15:0] apartment,
    input  logic [9:0]  area_code,
    input  logic [23:0] phone_number,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [63:0] out_name_head,
    output logic [7:0]  out_name_tail,
    output logic [15:0] out_apartment,
    output logic [9:0]  out_area_code,
    output logic [23:0] out_phone_number,
    output logic [3:0]  position,
    output logic        found,
    output logic        end_of_run
);

    rss_pkg::dp_cmd_t    cmd;
    rss_pkg::dp_status_t status;

    rss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .last     (last),
        .status   (status),
        .cmd      (cmd)
    );

    rss_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .mode             (mode),
        .name_head        (name_head),
        .name_tail        (name_tail),
        .apartment        (apartment),
        .area_code        (area_code),
        .phone_number     (phone_number),
        .last             (last),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .out_name_head    (out_name_head),
        .out_name_tail    (out_name_tail),
        .out_apartment    (out_apartment),
        .out_area_code    (out_area_code),
        .out_phone_number (out_phone_number),
        .position         (position),
        .found            (found),
        .end_of_run       (end_of_run)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the record sort and search block
// Loads batches of phone-book records, closes them to trigger the sort and
// searches the result. A behavioral copy of the table predicts every sorted
// record and every search answer; each output beat is checked field by field
// in order. Both handshakes idle at random, with some stretches at full rate.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 120;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_TAIL     = 40;

    typedef struct {
        logic        kind;
        logic [63:0] head;
        logic [7:0]  tail;
        logic [15:0] apt;
        logic [9:0]  area;
        logic [23:0] phone;
        logic [3:0]  pos;
        logic        found;
        logic        eor;
    } listing_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        mode;
    logic [63:0] name_head;
    logic [7:0]  name_tail;
    logic [15:0] apartment;
    logic [9:0]  area_code;
    logic [23:0] phone_number;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic        kind;
    logic [63:0] out_name_head;
    logic [7:0]  out_name_tail;
    logic [15:0] out_apartment;
    logic [9:0]  out_area_code;
    logic [23:0] out_phone_number;
    logic [3:0]  position;
    logic        found;
    logic        end_of_run;

    // Behavioral copy of the phone book.
    rss_pkg::rec_t book [rss_pkg::MaxRecords];
    int          book_count;
    bit          book_closed;
    listing_t    listing_q [$];
    logic [71:0] name_pool [6];

    bit steady;
    int sink_hold;
    int idle_cycles;
    int error_count;
    int items_sent;
    int loads_sent;
    int searches_sent;
    int batches_closed;
    int dropped_loads;
    int answers_hit;
    int answers_miss;
    int beats_checked;

    record_sort_and_search dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .name_head        (name_head),
        .name_tail        (name_tail),
        .apartment        (apartment),
        .area_code        (area_code),
        .phone_number     (phone_number),
        .last             (last),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .out_name_head    (out_name_head),
        .out_name_tail    (out_name_tail),
        .out_apartment    (out_apartment),
        .out_area_code    (out_area_code),
        .out_phone_number (out_phone_number),
        .position         (position),
        .found            (found),
        .end_of_run       (end_of_run)
    );

    always #2 clk = ~clk;

    // A name ends at its first zero byte; everything after it is cleared.
    function automatic logic [71:0] clean_name(logic [71:0] raw);
        logic        ended;
        logic [71:0] c;
        ended = 1'b0;
        c     = raw;
        for (int k = 0; k < 9; k++)
        begin
            if (raw[71 - 8 * k -: 8] == 8'd0)
                ended = 1'b1;
            if (ended)
                c[71 - 8 * k -: 8] = 8'd0;
        end
        return c;
    endfunction

    function automatic logic [71:0] make_name(int len, bit narrow);
        logic [71:0] n;
        n = '0;
        for (int k = 0; k < len; k++)
            n[71 - 8 * k -: 8] = narrow ? 8'($urandom_range(65, 68))
                                        : 8'($urandom_range(1, 255));
        return n;
    endfunction

    // Fills the bytes behind the terminating zero with garbage.
    function automatic logic [71:0] soil_name(logic [71:0] n);
        bit past;
        past = 1'b0;
        for (int k = 0; k < 9; k++)
        begin
            if (past)
                n[71 - 8 * k -: 8] = 8'($urandom_range(0, 255));
            else if (n[71 - 8 * k -: 8] == 8'd0)
                past = 1'b1;
        end
        return n;
    endfunction

    function automatic logic [71:0] raw_name();
        return {$urandom, $urandom, 8'($urandom_range(0, 255))};
    endfunction

    task automatic report_error(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_error($sformatf("%s got %0h expected %0h", field, got, want));
    endtask

    // Applies one accepted beat to the book and queues the beats it causes.
    task automatic book_step(logic m, logic [71:0] raw, logic [15:0] ap,
                             logic [9:0] ar, logic [23:0] ph, logic lst);
        logic [71:0]   key;
        listing_t      r;
        rss_pkg::rec_t tmp;
        bit            hit;
        key = clean_name(raw);
        hit = 1'b0;
        if (m == rss_pkg::MODE_LOAD)
        begin
            loads_sent++;
            if (book_closed)
            begin
                book_count  = 0;
                book_closed = 1'b0;
            end
            if (book_count < rss_pkg::MaxRecords)
            begin
                book[book_count].name         = key;
                book[book_count].apartment    = ap;
                book[book_count].area_code    = ar;
                book[book_count].phone_number = ph;
                book_count++;
            end
            else
                dropped_loads++;
            if (lst)
            begin
                book_closed = 1'b1;
                batches_closed++;
                // Swap only on strictly greater, so ties land exactly as the block puts them.
                for (int i = 0; i + 1 < book_count; i++)
                    for (int j = i + 1; j < book_count; j++)
                        if (book[i].name > book[j].name)
                        begin
                            tmp     = book[i];
                            book[i] = book[j];
                            book[j] = tmp;
                        end
                for (int i = 0; i < book_count; i++)
                begin
                    r.kind  = rss_pkg::KIND_RECORD;
                    r.head  = book[i].name.head;
                    r.tail  = book[i].name.tail;
                    r.apt   = book[i].apartment;
                    r.area  = book[i].area_code;
                    r.phone = book[i].phone_number;
                    r.pos   = 4'(i);
                    r.found = 1'b0;
                    r.eor   = (i + 1 == book_count);
                    listing_q.push_back(r);
                end
            end
        end
        else
        begin
            searches_sent++;
            r.kind  = rss_pkg::KIND_ANSWER;
            r.head  = '0;
            r.tail  = '0;
            r.apt   = '0;
            r.area  = '0;
            r.phone = '0;
            r.pos   = '0;
            r.found = 1'b0;
            r.eor   = 1'b1;
            for (int i = 0; i < book_count; i++)
                if (!hit && book[i].name == key)
                begin
                    hit     = 1'b1;
                    r.area  = book[i].area_code;
                    r.phone = book[i].phone_number;
                    r.pos   = 4'(i);
                    r.found = 1'b1;
                end
            if (hit)
                answers_hit++;
            else
                answers_miss++;
            listing_q.push_back(r);
        end
    endtask

    task automatic send_item(logic m, logic [71:0] raw, logic [15:0] ap,
                             logic [9:0] ar, logic [23:0] ph, logic lst);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        mode         <= m;
        name_head    <= raw[71:8];
        name_tail    <= raw[7:0];
        apartment    <= ap;
        area_code    <= ar;
        phone_number <= ph;
        last         <= lst;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        book_step(m, raw, ap, ar, ph, lst);
    endtask

    task automatic send_load(logic [71:0] raw, logic lst);
        send_item(rss_pkg::MODE_LOAD, raw, 16'($urandom_range(0, 65535)),
                  10'($urandom_range(0, 999)), 24'($urandom_range(0, 9999999)), lst);
    endtask

    // The numeric fields and last of a search beat are noise.
    task automatic send_search(logic [71:0] raw);
        send_item(rss_pkg::MODE_SEARCH, raw, 16'($urandom_range(0, 65535)),
                  10'($urandom_range(0, 999)), 24'($urandom_range(0, 9999999)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (listing_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [71:0] pick_load_name();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return name_pool[$urandom_range(0, 5)];
        if (sel < 6)
            return soil_name(name_pool[$urandom_range(0, 5)]);
        if (sel < 8)
            return make_name($urandom_range(0, 9), 1'b0);
        return raw_name();
    endfunction

    function automatic logic [71:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (book_count > 0 && sel < 6)
            return soil_name(book[$urandom_range(0, book_count - 1)].name);
        if (sel < 8)
            return pick_load_name();
        return raw_name();
    endfunction

    task automatic test_empty_table_search();
        send_search(make_name(3, 1'b0));
        send_search('0);
    endtask

    task automatic test_field_extremes();
        send_item(rss_pkg::MODE_LOAD, '1, 16'hFFFF, 10'd999, 24'd9999999, 1'b0);
        send_item(rss_pkg::MODE_LOAD, '0, 16'h0000, 10'd0, 24'd0, 1'b0);
        send_item(rss_pkg::MODE_LOAD, {8'h01, 64'd0}, 16'h8000, 10'd512, 24'h800000,
                  1'b0);
        send_item(rss_pkg::MODE_LOAD, {8'hFF, 8'h00, 56'h123456789ABCDE}, 16'h5555,
                  10'h2AA, 24'h555555, 1'b1);
        send_search('1);
        send_search('0);
        send_search(soil_name({8'h01, 64'd0}));
    endtask

    task automatic test_equal_names();
        logic [71:0] ab;
        ab = {16'h4142, 56'd0};
        send_item(rss_pkg::MODE_LOAD, soil_name(ab), 16'd1, 10'd11, 24'd111, 1'b0);
        send_item(rss_pkg::MODE_LOAD, {8'h42, 64'd0}, 16'd2, 10'd22, 24'd222, 1'b0);
        send_item(rss_pkg::MODE_LOAD, ab, 16'd3, 10'd33, 24'd333, 1'b0);
        // The batch is still open, so this scans in load order.
        send_search(soil_name(ab));
        send_item(rss_pkg::MODE_LOAD, soil_name({16'h4141, 56'd0}), 16'd4, 10'd44,
                  24'd444, 1'b0);
        send_item(rss_pkg::MODE_LOAD, ab, 16'd5, 10'd55, 24'd555, 1'b1);
        send_search(ab);
        send_search({24'h414243, 48'd0});
    endtask

    task automatic test_new_table();
        send_load({8'h5A, 64'd0}, 1'b1);
        send_search({8'h42, 64'd0});
        send_search({8'h5A, 64'd0});
    endtask

    task automatic test_full_table();
        logic [71:0] kept;
        logic [71:0] dropped;
        kept = '0;
        dropped = '0;
        for (int k = 0; k < rss_pkg::MaxRecords + 2; k++)
        begin
            dropped = make_name($urandom_range(1, 9), 1'b0);
            if (k == 3)
                kept = dropped;
            send_load(dropped, k == rss_pkg::MaxRecords + 1);
        end
        // Hold the sender until the whole listing has drained.
        wait_drained();
        send_search(kept);
        send_search(dropped);
    endtask

    task automatic test_random_batches();
        int start;
        int batch_no;
        int size;
        int sel;
        bit close;
        start    = items_sent;
        batch_no = 0;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            batch_no++;
            steady = (batch_no % 5 == 0);
            for (int k = 0; k < 6; k++)
                name_pool[k] = make_name($urandom_range(1, 4), 1'b1);
            sel   = $urandom_range(0, 19);
            size  = (sel < 16) ? $urandom_range(1, 6)
                  : (sel < 19) ? $urandom_range(7, rss_pkg::MaxRecords)
                               : $urandom_range(17, 20);
            close = ($urandom_range(0, 9) != 0);
            for (int k = 0; k < size; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_search(pick_key());
                send_load(pick_load_name(), close && (k == size - 1));
            end
            sel = $urandom_range(1, 4);
            for (int k = 0; k < sel; k++)
                send_search(pick_key());
            if (batch_no % 7 == 0)
                wait_drained();
        end
        steady = 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (sink_hold > 0)
        begin
            out_ready <= 1'b0;
            sink_hold--;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        listing_t want;
        if (rst_n && out_valid && out_ready)
        begin
            sink_hold = steady ? 0 : $urandom_range(0, 5);
            beats_checked++;
            if (listing_q.size() == 0)
                report_error("result beat arrived with nothing expected");
            else
            begin
                want = listing_q.pop_front();
                check_field("kind", 64'(kind), 64'(want.kind));
                check_field("out_name_head", out_name_head, want.head);
                check_field("out_name_tail", 64'(out_name_tail), 64'(want.tail));
                check_field("out_apartment", 64'(out_apartment), 64'(want.apt));
                check_field("out_area_code", 64'(out_area_code), 64'(want.area));
                check_field("out_phone_number", 64'(out_phone_number),
                            64'(want.phone));
                check_field("position", 64'(position), 64'(want.pos));
                check_field("found", 64'(found), 64'(want.found));
                check_field("end_of_run", 64'(end_of_run), 64'(want.eor));
            end
        end
    end

    // A long sort moves no beat for a while, so the limit sits well above it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("Watchdog: no beat moved for %0d cycles", idle_cycles);
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = rss_pkg::MODE_LOAD;
        name_head    = '0;
        name_tail    = '0;
        apartment    = '0;
        area_code    = '0;
        phone_number = '0;
        last         = 1'b0;
        out_ready    = 1'b0;
        steady       = 1'b0;
        sink_hold    = 0;
        idle_cycles  = 0;
        book_count   = 0;
        book_closed  = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table_search();
        test_field_extremes();
        test_equal_names();
        test_new_table();
        test_full_table();
        test_random_batches();

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge clk);
        $display("Sent %0d beats: %0d loads (%0d dropped on a full table), %0d searches",
                 items_sent, loads_sent, dropped_loads, searches_sent);
        $display("Checked %0d result beats over %0d sorted batches, %0d hits, %0d misses",
                 beats_checked, batches_closed, answers_hit, answers_miss);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/rss_pkg.sv
design/rss_ctrl.sv
design/rss_datapath.sv
design/record_sort_and_search.sv
tb/sv/tb_top.sv
